// ===== src/assert_macros.svh =====
// assertion macros shared by the rtl files
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`define ASSERT_IMPL(label, clk, rst_n, a, c) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
        else $error("assertion failed");
`define ASSERT_NEXT(label, clk, rst_n, a, c) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
        else $error("assertion failed");
`endif

// ===== src/icb_pkg.sv =====
// types and constants of the crop and bin block
`default_nettype none
package icb_pkg;
    typedef struct packed {
        logic signed [31:0] sci_in;
        logic signed [23:0] err_in;
        logic [15:0]        quality_in;
        logic               frame_end;
    } t_in_word;

    typedef struct packed {
        logic signed [39:0] sci_out;
        logic signed [27:0] err_out;
        logic [15:0]        quality_out;
        logic               size_error;
        logic               last_out;
    } t_out_word;

    // finished bin handed from front to back
    typedef struct packed {
        logic signed [39:0] sci;
        logic [54:0]        esq;
        logic signed [23:0] e;
        logic [15:0]        q;
        logic [9:0]         area;
        logic               avg;
        logic               err;
        logic               last;
    } t_job;

    localparam logic [2:0] REG_X_CORNER = 3'd0;
    localparam logic [2:0] REG_Y_CORNER = 3'd1;
    localparam logic [2:0] REG_BIN_X    = 3'd2;
    localparam logic [2:0] REG_BIN_Y    = 3'd3;
    localparam logic [2:0] REG_AVERAGE  = 3'd4;
    localparam logic [2:0] REG_OUT_W    = 3'd5;
    localparam logic [2:0] REG_OUT_H    = 3'd6;
    localparam logic [2:0] REG_IN_W     = 3'd7;

    localparam logic [12:0] ROW_LIMIT = 13'd8191;
    localparam logic [27:0] ERR_MAX = 28'd134217727;
endpackage
`default_nettype wire

// ===== src/icb_front.sv =====
// front: window tracking, per-column accumulation, bin completion
`default_nettype none
module icb_front #(
    parameter int MAX_OUT_WIDTH = 1024,
    parameter int MAX_BIN = 16,
    parameter int MAX_IN_WIDTH = 4096
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_valid,
    output logic                  o_stall,
    input  wire icb_pkg::t_in_word i_word,
    input  wire logic [11:0]      i_x_corner,
    input  wire logic [11:0]      i_y_corner,
    input  wire logic [4:0]       i_bin_x,
    input  wire logic [4:0]       i_bin_y,
    input  wire logic             i_average,
    input  wire logic [10:0]      i_out_w,
    input  wire logic [12:0]      i_out_h,
    input  wire logic [12:0]      i_in_w,
    output logic                  o_job_valid,
    input  wire logic             i_job_stall,
    output icb_pkg::t_job         o_job
);
    localparam int AW = $clog2(MAX_OUT_WIDTH);
    // S_IN registers the pixel and its position, S_RD reads the memory, S_WR does the memory update
    typedef enum logic [1:0] {S_IN, S_RD, S_WR, S_OUT} t_state;
    t_state r_state;

    logic [12:0] r_col, r_row;
    logic        r_err_seen;
    logic [4:0]  r_sx, r_sy;          // position inside the bin
    logic [AW-1:0] r_m;
    logic [12:0] r_n;
    icb_pkg::t_in_word r_px;
    logic        r_inwin, r_bad, r_fend, r_done;

    logic signed [39:0] mem_s [MAX_OUT_WIDTH];
    logic [54:0]        mem_e [MAX_OUT_WIDTH];
    logic [15:0]        mem_q [MAX_OUT_WIDTH];
    logic signed [39:0] r_rs;
    logic [54:0]        r_re;
    logic [15:0]        r_rq;
    logic signed [47:0] r_esq;
    icb_pkg::t_job      r_pend;
    icb_pkg::t_job      r_job;
    logic               r_jv;

    logic [16:0] x_end;
    logic [17:0] y_end;
    logic        bad;
    logic        inwin;
    logic        first, lastpx;

    always_comb begin
        x_end = 17'(i_x_corner) + 17'(i_out_w) * 17'(i_bin_x);
        y_end = 18'(i_y_corner) + 18'(i_out_h) * 18'(i_bin_y);
        bad = i_bin_x < 5'd1 || 32'(i_bin_x) > MAX_BIN || i_bin_y < 5'd1 ||
              32'(i_bin_y) > MAX_BIN || i_out_w < 11'd1 ||
              32'(i_out_w) > MAX_OUT_WIDTH || i_out_h < 13'd1 ||
              i_in_w < 13'd1 || 32'(i_in_w) > MAX_IN_WIDTH ||
              x_end > 17'(i_in_w) || y_end > 18'(icb_pkg::ROW_LIMIT);
        inwin = 13'(r_col) >= 13'(i_x_corner) && 17'(r_col) < x_end &&
                r_row >= 13'(i_y_corner) && 18'(r_row) < y_end;
        first = r_sx == 5'd0 && r_sy == 5'd0;
        lastpx = r_sx == i_bin_x - 5'd1 && r_sy == i_bin_y - 5'd1;
    end

    assign o_stall = r_state != S_IN;
    assign o_job_valid = r_jv;
    assign o_job = r_job;

    // bin coordinates are tracked incrementally alongside the counters
    logic [4:0]  r_bxc, r_byc;
    logic [AW-1:0] r_mc;
    logic [12:0] r_nc;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IN;
            r_col <= '0; r_row <= '0; r_err_seen <= 1'b0; r_jv <= 1'b0;
            r_bxc <= '0; r_byc <= '0; r_mc <= '0; r_nc <= '0;
        end else begin
            r_jv <= (r_jv && i_job_stall) ||
                    (r_state == S_OUT && (!r_jv || !i_job_stall));
            case (r_state)
                S_IN: if (i_valid) begin
                    r_px <= i_word;
                    r_fend <= i_word.frame_end;
                    r_bad <= bad;
                    r_inwin <= inwin && !bad && !r_err_seen;
                    r_sx <= r_bxc; r_sy <= r_byc; r_m <= r_mc; r_n <= r_nc;
                    r_done <= 18'(r_row) > y_end - 18'd1 ||
                              (18'(r_row) == y_end - 18'd1 && 17'(r_col) >= x_end - 17'd1);
                    // advance position counters
                    if (r_err_seen || bad || i_word.frame_end) begin
                        if (i_word.frame_end || r_err_seen || bad) begin
                            if (i_word.frame_end) begin
                                r_col <= '0; r_row <= '0; r_err_seen <= 1'b0;
                            end else if (bad) begin
                                r_err_seen <= 1'b1;
                            end
                        end
                        r_bxc <= '0; r_byc <= '0; r_mc <= '0; r_nc <= '0;
                    end else begin
                        if (r_col + 13'd1 >= i_in_w) begin
                            r_col <= '0;
                            if (r_row < icb_pkg::ROW_LIMIT) r_row <= r_row + 13'd1;
                        end else begin
                            r_col <= r_col + 13'd1;
                        end
                        if (inwin) begin
                            if (r_bxc == i_bin_x - 5'd1) begin
                                r_bxc <= '0;
                                if (32'(r_mc) == 32'(i_out_w) - 1) begin
                                    r_mc <= '0;
                                    if (r_byc == i_bin_y - 5'd1) begin
                                        r_byc <= '0; r_nc <= r_nc + 13'd1;
                                    end else begin
                                        r_byc <= r_byc + 5'd1;
                                    end
                                end else begin
                                    r_mc <= r_mc + AW'(1);
                                end
                            end else begin
                                r_bxc <= r_bxc + 5'd1;
                            end
                        end
                    end
                    r_state <= r_err_seen ? S_IN : S_RD;
                end
                S_RD: begin
                    r_rs <= mem_s[r_m]; r_re <= mem_e[r_m]; r_rq <= mem_q[r_m];
                    r_esq <= 48'(r_px.err_in) * 48'(r_px.err_in);
                    r_state <= S_WR;
                end
                S_WR: begin
                    r_pend.sci <= first ? 40'(r_px.sci_in) : r_rs + 40'(r_px.sci_in);
                    r_pend.esq <= first ? 55'(r_esq) : r_re + 55'(r_esq);
                    r_pend.q <= first ? r_px.quality_in : r_rq | r_px.quality_in;
                    r_pend.e <= r_px.err_in;
                    r_pend.area <= 10'(i_bin_x) * 10'(i_bin_y);
                    r_pend.avg <= i_average;
                    r_pend.err <= r_bad || (r_fend && !r_done);
                    r_pend.last <= r_bad || (r_fend && !r_done) ||
                        (32'(r_m) == 32'(i_out_w) - 1 && r_n == i_out_h - 13'd1);
                    r_state <= (r_bad || (r_inwin && lastpx) || (r_fend && !r_done))
                               ? S_OUT : S_IN;
                end
                S_OUT: if (!r_jv || !i_job_stall) begin
                    r_job <= r_pend;
                    r_state <= S_IN;
                end
                default: r_state <= S_IN;
            endcase
        end
    end

    // clocked memory write of the accumulated bin
    always_ff @(posedge i_clk) begin
        if (r_state == S_WR && r_inwin) begin
            mem_s[r_m] <= first ? 40'(r_px.sci_in) : r_rs + 40'(r_px.sci_in);
            mem_e[r_m] <= first ? 55'(r_esq) : r_re + 55'(r_esq);
            mem_q[r_m] <= first ? r_px.quality_in : r_rq | r_px.quality_in;
        end
    end

    `include "assert_macros.svh"
    `ASSERT_IMPL(a_stall_busy, i_clk, i_rst_n, r_state != S_IN, o_stall)
    `ASSERT_NEXT(a_job_after_out, i_clk, i_rst_n, r_state == S_OUT && !(r_jv && i_job_stall), r_jv)
    `ASSERT_IMPL(a_err_last, i_clk, i_rst_n, r_jv && r_job.err, r_job.last)
endmodule
`default_nettype wire

// ===== src/icb_back.sv =====
// back: square root, area divide and output register
`default_nettype none
module icb_back (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_job_valid,
    output logic                   o_job_stall,
    input  wire icb_pkg::t_job     i_job,
    output logic                   o_valid,
    input  wire logic              i_stall,
    output icb_pkg::t_out_word     o_word
);
    typedef enum logic [2:0] {S_IDLE, S_SQRT, S_DIV1, S_DIV2, S_DONE} t_state;
    t_state r_state;
    icb_pkg::t_job r_j;
    logic [54:0] r_v;
    logic [27:0] r_res;           // 55-bit sum has a 28-bit root
    logic [4:0]  r_k;
    logic [39:0] r_sn, r_sq;      // science magnitude and quotient
    logic [27:0] r_en, r_eq;
    logic [39:0] r_rem_s;
    logic [27:0] r_rem_e;
    logic [5:0]  r_i;
    logic        r_neg;
    icb_pkg::t_out_word r_out;
    logic        r_ov;

    logic [40:0] ts;
    logic [28:0] te;
    always_comb begin
        ts = {r_rem_s, r_sn[39]} - 41'(r_j.area);
        te = {r_rem_e, r_en[27]} - 29'(r_j.area);
    end

    assign o_job_stall = r_state != S_IDLE;
    assign o_valid = r_ov;
    assign o_word = r_out;

    logic [55:0] rem2;
    logic [29:0] cand;
    logic [55:0] r_rem;
    always_comb begin
        rem2 = (r_rem << 2) | 56'((r_v >> (2 * r_k)) & 55'd3);
        cand = {r_res, 2'b01};
    end

    icb_pkg::t_out_word n_out;
    logic               out_load;
    always_comb begin
        n_out = '0;
        if (r_j.err) begin
            n_out.size_error = 1'b1;
            n_out.last_out = 1'b1;
        end else begin
            n_out.sci_out = r_neg ? 40'(-r_sn) : r_sn;
            n_out.err_out = r_j.area == 10'd1 ? 28'(r_j.e) : r_en;
            n_out.quality_out = r_j.q;
            n_out.last_out = r_j.last;
        end
        out_load = r_state == S_DONE && (!r_ov || !i_stall);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE; r_ov <= 1'b0;
        end else begin
            r_ov <= (r_ov && i_stall) || out_load;
            case (r_state)
                S_IDLE: if (i_job_valid) begin
                    r_j <= i_job; r_v <= i_job.esq;
                    r_res <= '0; r_rem <= '0; r_k <= 5'd27;
                    r_state <= S_SQRT;
                end
                // one root bit per cycle, restoring
                S_SQRT: begin
                    if (rem2 >= 56'(cand)) begin
                        r_rem <= rem2 - 56'(cand); r_res <= {r_res[26:0], 1'b1};
                    end else begin
                        r_rem <= rem2; r_res <= {r_res[26:0], 1'b0};
                    end
                    if (r_k == 5'd0) r_state <= S_DIV1;
                    else r_k <= r_k - 5'd1;
                end
                S_DIV1: begin
                    r_neg <= r_j.sci[39];
                    r_sn <= r_j.sci[39] ? 40'(-r_j.sci) : r_j.sci;
                    r_en <= r_res > icb_pkg::ERR_MAX ? icb_pkg::ERR_MAX : r_res;
                    r_rem_s <= '0; r_rem_e <= '0; r_i <= 6'd0;
                    r_state <= (r_j.avg && r_j.area != 10'd1) ? S_DIV2 : S_DONE;
                end
                // shift-subtract divide by area, one bit per cycle
                S_DIV2: begin
                    if (!ts[40]) begin
                        r_rem_s <= ts[39:0]; r_sn <= {r_sn[38:0], 1'b1};
                    end else begin
                        r_rem_s <= {r_rem_s[38:0], r_sn[39]}; r_sn <= {r_sn[38:0], 1'b0};
                    end
                    if (r_i < 6'd28) begin
                        if (!te[28]) begin
                            r_rem_e <= te[27:0]; r_en <= {r_en[26:0], 1'b1};
                        end else begin
                            r_rem_e <= {r_rem_e[26:0], r_en[27]}; r_en <= {r_en[26:0], 1'b0};
                        end
                    end
                    if (r_i == 6'd39) r_state <= S_DONE;
                    r_i <= r_i + 6'd1;
                end
                S_DONE: if (out_load) begin
                    r_out <= n_out;
                    r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    `include "assert_macros.svh"
    `ASSERT_IMPL(a_busy_stall, i_clk, i_rst_n, r_state != S_IDLE, o_job_stall)
    `ASSERT_IMPL(a_err_zero, i_clk, i_rst_n, r_ov && r_out.size_error, r_out.sci_out == 40'd0)
endmodule
`default_nettype wire

// ===== src/image_crop_and_bin.sv =====
// top level of the crop and bin block
// channel | dir | handshake     | word
// in      | in  | valid/stall   | t_in_word
// out     | out | valid/stall   | t_out_word
// cfg     | in  | valid/ready   | index, data
// a pixel goes through register, memory read and memory write in the front, unless an error was seen
// a bin's last pixel then goes through an output state that hands the bin to the back
// a finished bin goes through the back's 28-step root, then in average mode (area above one) an area divide
// the front waits in its output state while the back still holds an earlier bin
// synchronous active-low reset; accumulator memories are not cleared
`default_nettype none
module image_crop_and_bin #(
    parameter int MAX_OUT_WIDTH = 1024,
    parameter int MAX_BIN = 16,
    parameter int MAX_IN_WIDTH = 4096
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_valid,
    output logic                    o_stall,
    input  wire icb_pkg::t_in_word  i_word,
    output logic                    o_valid,
    input  wire logic               i_stall,
    output icb_pkg::t_out_word      o_word,
    input  wire logic               i_cfg_valid,
    output logic                    o_cfg_ready,
    input  wire logic [2:0]         i_cfg_index,
    input  wire logic [12:0]        i_cfg_data
);
    logic [11:0] r_xc, r_yc;
    logic [4:0]  r_bx, r_by;
    logic        r_avg;
    logic [10:0] r_ow;
    logic [12:0] r_oh, r_iw;
    logic        job_valid, job_stall;
    icb_pkg::t_job job;

    assign o_cfg_ready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_xc <= '0; r_yc <= '0; r_bx <= 5'd1; r_by <= 5'd1; r_avg <= 1'b1;
            r_ow <= 11'd1; r_oh <= 13'd1; r_iw <= 13'd1;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                icb_pkg::REG_X_CORNER: r_xc <= i_cfg_data[11:0];
                icb_pkg::REG_Y_CORNER: r_yc <= i_cfg_data[11:0];
                icb_pkg::REG_BIN_X:    r_bx <= i_cfg_data[4:0];
                icb_pkg::REG_BIN_Y:    r_by <= i_cfg_data[4:0];
                icb_pkg::REG_AVERAGE:  r_avg <= i_cfg_data[0];
                icb_pkg::REG_OUT_W:    r_ow <= i_cfg_data[10:0];
                icb_pkg::REG_OUT_H:    r_oh <= i_cfg_data;
                icb_pkg::REG_IN_W:     r_iw <= i_cfg_data;
                default: ;
            endcase
        end
    end

    icb_front #(.MAX_OUT_WIDTH(MAX_OUT_WIDTH), .MAX_BIN(MAX_BIN),
                .MAX_IN_WIDTH(MAX_IN_WIDTH)) u_front (
        .i_clk, .i_rst_n, .i_valid, .o_stall, .i_word,
        .i_x_corner(r_xc), .i_y_corner(r_yc), .i_bin_x(r_bx), .i_bin_y(r_by),
        .i_average(r_avg), .i_out_w(r_ow), .i_out_h(r_oh), .i_in_w(r_iw),
        .o_job_valid(job_valid), .i_job_stall(job_stall), .o_job(job)
    );

    icb_back u_back (
        .i_clk, .i_rst_n, .i_job_valid(job_valid), .o_job_stall(job_stall),
        .i_job(job), .o_valid, .i_stall, .o_word
    );
endmodule
`default_nettype wire
